// ===== rtl/priority_sorted_task_queue_macros.svh =====
// Assertion macros used by the priority task queue top level.
`ifndef PRIORITY_SORTED_TASK_QUEUE_MACROS_SVH
`define PRIORITY_SORTED_TASK_QUEUE_MACROS_SVH

`ifndef SYNTH
// Check a property at every rising clock edge outside reset.
`define PSTQ_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("pstq assertion failed");
// Check that a condition implies another one in the next cycle.
`define PSTQ_ASSERT_NEXT(lbl, clk, rstn, cond, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (cond) |=> (expr)) \
        else $error("pstq assertion failed");
`else
`define PSTQ_ASSERT(lbl, clk, rstn, prop)
`define PSTQ_ASSERT_NEXT(lbl, clk, rstn, cond, expr)
`endif

`endif

// ===== rtl/pstq_pkg.sv =====
// Package with the shared constants and types of the priority task queue.
package pstq_pkg;

    // Default sizes of the list.
    localparam int MAX_TASKS_DEF     = 16;
    localparam int PRIORITY_BITS_DEF = 8;

    // Fixed widths of the word fields.
    localparam int TASK_ID_W  = 4;
    localparam int PRIO_REQ_W = 8;
    localparam int SLOT_W     = 4;
    localparam int COUNT_W    = 5;

    // Command broadcast to every cell in the cycle the list changes.
    typedef struct packed {
        logic ins;
        logic rem;
    } cell_cmd_t;

    // Per-cell compare results.
    typedef struct packed {
        logic match;
        logic lower;
        logic edge_hit;
    } cell_stat_t;

endpackage

// ===== rtl/pstq_req_if.sv =====
// Request channel of the priority task queue.
interface pstq_req_if;
    logic                                valid;
    logic                                ready;
    logic                                enable;
    logic [pstq_pkg::TASK_ID_W-1:0]      task_id;
    logic [pstq_pkg::PRIO_REQ_W-1:0]     priority_req;

    modport source (output valid, output enable, output task_id, output priority_req,
                    input ready);
    modport sink (input valid, input enable, input task_id, input priority_req,
                  output ready);
endinterface

// ===== rtl/pstq_rsp_if.sv =====
// Response channel of the priority task queue.
interface pstq_rsp_if;
    logic                             valid;
    logic                             ready;
    logic                             accepted;
    logic [pstq_pkg::SLOT_W-1:0]      slot;
    logic [pstq_pkg::COUNT_W-1:0]     entry_count;

    modport source (output valid, output accepted, output slot, output entry_count,
                    input ready);
    modport sink (input valid, input accepted, input slot, input entry_count,
                  output ready);
endinterface

// ===== rtl/priority_sorted_task_queue.sv =====
// Top level of the priority task queue: request capture, cell row and response register.
//
// Usage: the req channel carries one word per request: enable=1 inserts task_id with
// priority_req, enable=0 removes task_id. The list stays sorted by descending priority,
// equal priorities keep arrival order. Each request yields exactly one word on the rsp
// channel: accepted, the slot inserted at or removed from (0 when refused) and the
// number of entries afterwards.
// The request is captured first; every cell then compares against it in parallel and
// shifts by one position, and the response word is written into the response register.
// No new request is taken until that compare-and-shift step is done.
// A stalled receiver holds the finished response; a new request is still taken, and
// its compare-and-shift cycle waits until the response register is free.
// Reset empties the list at once (count cleared); slot contents need no clearing.
`include "priority_sorted_task_queue_macros.svh"

module priority_sorted_task_queue #(
    parameter int MAX_TASKS     = pstq_pkg::MAX_TASKS_DEF,
    parameter int PRIORITY_BITS = pstq_pkg::PRIORITY_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    pstq_req_if.sink    req,
    pstq_rsp_if.source  rsp
);
    import pstq_pkg::*;

    localparam int IDX_W = $clog2(MAX_TASKS);
    localparam int CNT_W = $clog2(MAX_TASKS + 1);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_BUSY = 1'b1;

    logic                     state_reg, state_next;
    logic [CNT_W-1:0]         count_reg, count_next;
    logic                     en_reg;
    logic [TASK_ID_W-1:0]     id_reg;
    logic [PRIORITY_BITS-1:0] prio_reg;

    logic                     rsp_valid_reg, rsp_valid_next;
    logic                     rsp_acc_reg, rsp_acc_next;
    logic [SLOT_W-1:0]        rsp_slot_reg, rsp_slot_next;
    logic [COUNT_W-1:0]       rsp_cnt_reg, rsp_cnt_next;

    cell_cmd_t                cmd;
    cell_stat_t               stat [MAX_TASKS];
    logic [TASK_ID_W-1:0]     cell_task [MAX_TASKS];
    logic [PRIORITY_BITS-1:0] cell_prio [MAX_TASKS];
    logic [MAX_TASKS-1:0]     occ_vec;
    logic [MAX_TASKS-1:0]     match_vec;
    logic [MAX_TASKS-1:0]     hit_vec;
    logic [IDX_W-1:0]         where;
    logic                     found;
    logic                     done;
    logic                     accept;

    // Row of cells; each one sees its neighbors' contents.
    for (genvar i = 0; i < MAX_TASKS; i++)
    begin : g_cell
        logic                     l_lower;
        logic [TASK_ID_W-1:0]     l_task;
        logic [PRIORITY_BITS-1:0] l_prio;
        logic [TASK_ID_W-1:0]     r_task;
        logic [PRIORITY_BITS-1:0] r_prio;

        assign occ_vec[i]   = (count_reg > CNT_W'(i));
        assign match_vec[i] = stat[i].match;
        assign hit_vec[i]   = en_reg ? stat[i].edge_hit : stat[i].match;

        if (i == 0)
        begin : g_first
            assign l_lower = 1'b0;
            assign l_task  = '0;
            assign l_prio  = '0;
        end
        else
        begin : g_inner
            assign l_lower = stat[i-1].lower;
            assign l_task  = cell_task[i-1];
            assign l_prio  = cell_prio[i-1];
        end

        if (i == MAX_TASKS - 1)
        begin : g_last
            assign r_task = '0;
            assign r_prio = '0;
        end
        else
        begin : g_body
            assign r_task = cell_task[i+1];
            assign r_prio = cell_prio[i+1];
        end

        pstq_cell #(
            .PRIORITY_BITS (PRIORITY_BITS),
            .IDX_W         (IDX_W),
            .IDX           (i)
        ) u_cell (
            .clk        (clk),
            .cmd        (cmd),
            .occ        (occ_vec[i]),
            .req_id     (id_reg),
            .req_prio   (prio_reg),
            .where      (where),
            .left_lower (l_lower),
            .left_task  (l_task),
            .left_prio  (l_prio),
            .right_task (r_task),
            .right_prio (r_prio),
            .task_out   (cell_task[i]),
            .prio_out   (cell_prio[i]),
            .stat       (stat[i])
        );
    end

    // Turn the one-hot hit into a slot index.
    always_comb
    begin
        where = '0;
        for (int i = 0; i < MAX_TASKS; i++)
        begin
            if (hit_vec[i])
            begin
                where = where | IDX_W'(i);
            end
        end
    end

    assign found  = |match_vec;
    assign done   = (state_reg == ST_BUSY) && (!rsp_valid_reg || rsp.ready);
    assign accept = en_reg ? (!found && (count_reg < CNT_W'(MAX_TASKS))) : found;

    assign cmd.ins = done && accept && en_reg;
    assign cmd.rem = done && accept && !en_reg;

    // Sequencing, count and response register.
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        rsp_valid_next = rsp_valid_reg;
        rsp_acc_next   = rsp_acc_reg;
        rsp_slot_next  = rsp_slot_reg;
        rsp_cnt_next   = rsp_cnt_reg;
        if (rsp_valid_reg && rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    state_next = ST_BUSY;
                end
            end
            ST_BUSY:
            begin
                if (done)
                begin
                    if (cmd.ins)
                    begin
                        count_next = count_reg + CNT_W'(1);
                    end
                    else if (cmd.rem)
                    begin
                        count_next = count_reg - CNT_W'(1);
                    end
                    rsp_valid_next = 1'b1;
                    rsp_acc_next   = accept;
                    rsp_slot_next  = accept ? SLOT_W'(where) : '0;
                    rsp_cnt_next   = COUNT_W'(count_next);
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Captured request and response payload.
    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            en_reg   <= req.enable;
            id_reg   <= req.task_id;
            prio_reg <= PRIORITY_BITS'(req.priority_req);
        end
        rsp_acc_reg  <= rsp_acc_next;
        rsp_slot_reg <= rsp_slot_next;
        rsp_cnt_reg  <= rsp_cnt_next;
    end

    assign req.ready       = (state_reg == ST_IDLE);
    assign rsp.valid       = rsp_valid_reg;
    assign rsp.accepted    = rsp_acc_reg;
    assign rsp.slot        = rsp_slot_reg;
    assign rsp.entry_count = rsp_cnt_reg;

    `PSTQ_ASSERT(a_count_max, clk, rst_n, count_reg <= CNT_W'(MAX_TASKS))
    `PSTQ_ASSERT(a_id_unique, clk, rst_n, $onehot0(match_vec))
    `PSTQ_ASSERT_NEXT(a_ins_count, clk, rst_n, cmd.ins,
        count_reg == $past(count_reg) + CNT_W'(1))
    `PSTQ_ASSERT_NEXT(a_rem_count, clk, rst_n, cmd.rem,
        count_reg == $past(count_reg) - CNT_W'(1))
    `PSTQ_ASSERT(a_rsp_source, clk, rst_n, $rose(rsp_valid_reg) |-> $past(done))

endmodule

// ===== rtl/pstq_cell.sv =====
// One list slot: holds a task id and priority and shifts to or from its neighbors.
module pstq_cell #(
    parameter int PRIORITY_BITS = pstq_pkg::PRIORITY_BITS_DEF,
    parameter int IDX_W         = 4,
    parameter int IDX           = 0
) (
    input  logic                             clk,
    input  pstq_pkg::cell_cmd_t              cmd,
    input  logic                             occ,
    input  logic [pstq_pkg::TASK_ID_W-1:0]   req_id,
    input  logic [PRIORITY_BITS-1:0]         req_prio,
    input  logic [IDX_W-1:0]                 where,
    input  logic                             left_lower,
    input  logic [pstq_pkg::TASK_ID_W-1:0]   left_task,
    input  logic [PRIORITY_BITS-1:0]         left_prio,
    input  logic [pstq_pkg::TASK_ID_W-1:0]   right_task,
    input  logic [PRIORITY_BITS-1:0]         right_prio,
    output logic [pstq_pkg::TASK_ID_W-1:0]   task_out,
    output logic [PRIORITY_BITS-1:0]         prio_out,
    output pstq_pkg::cell_stat_t             stat
);
    import pstq_pkg::*;

    logic [TASK_ID_W-1:0]     task_reg, task_next;
    logic [PRIORITY_BITS-1:0] prio_reg, prio_next;
    logic                     lower;
    logic                     at_or_after;

    // An empty slot or one of strictly lower priority lies at or past the insert point.
    assign lower        = !occ || (req_prio > prio_reg);
    assign stat.lower    = lower;
    assign stat.edge_hit = lower && !left_lower;
    assign stat.match    = occ && (task_reg == req_id);
    assign at_or_after   = (IDX_W'(IDX) >= where);

    // Insert shifts the tail right by one; removal pulls it left by one.
    always_comb
    begin
        task_next = task_reg;
        prio_next = prio_reg;
        if (cmd.ins)
        begin
            if (stat.edge_hit)
            begin
                task_next = req_id;
                prio_next = req_prio;
            end
            else if (left_lower)
            begin
                task_next = left_task;
                prio_next = left_prio;
            end
        end
        else if (cmd.rem && at_or_after)
        begin
            task_next = right_task;
            prio_next = right_prio;
        end
    end

    always_ff @(posedge clk)
    begin
        task_reg <= task_next;
        prio_reg <= prio_next;
    end

    assign task_out = task_reg;
    assign prio_out = prio_reg;

endmodule
